>>> rtl/tfd_pkg.sv
package tfd_pkg;

  // Header layout, little-endian, byte 0 first on the wire.
  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned HDR_W     = HDR_BYTES * 8;
  localparam int unsigned HIDX_W    = 4;

  // Result kinds carried on out_tuser.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAGIC   = 3'd0;
  localparam logic [2:0] REG_VERSION = 3'd1;
  localparam logic [2:0] REG_TYPE_LO = 3'd2;
  localparam logic [2:0] REG_TYPE_HI = 3'd3;
  localparam logic [2:0] REG_LIMIT   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_MAGIC   = 16'h0000;
  localparam logic [7:0]  RST_VERSION = 8'd1;
  localparam logic [7:0]  RST_TYPE_LO = 8'd1;
  localparam logic [7:0]  RST_TYPE_HI = 8'd255;
  localparam logic [31:0] RST_LIMIT   = 32'd65536;

  // Result word layout on out_tdata, highest field first.
  localparam int unsigned OUT_DATA_W = 80;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] payload_length;
    logic [31:0] stream_id;
    logic [7:0]  frame_type;
  } out_data_t;

endpackage

>>> rtl/tunnel_frame_deframer_top.sv
// Channel  | Direction | tdata                                        | tuser        | tlast
// in_      | input     | [7:0] data_byte                              | -            | -
// out_     | output    | [7:0] frame_type, [39:8] stream_id,          | result_kind  | last_of_frame
//          |           | [71:40] payload_length, [79:72] payload_byte |              |
// cfg_     | input     | write enable, index, 32-bit data             | -            | -
//
// One byte is taken per clock while the output register is not stalled; the header
// check and the payload pass-through both sit between the input and the single
// output register, so a result appears in the cycle after its byte is accepted.
// The output register stalls the input only while it holds an untaken word.
// Reset (rst_n low, synchronous) clears the parser control state, the sticky
// failure and the configuration registers back to their defaults; hdr_r is not reset.
module tunnel_frame_deframer_top
  import tfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream: data_byte.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // frame_type, stream_id, payload_length, payload_byte (lowest first).
  output logic [OUT_DATA_W-1:0] out_tdata,
  // result_kind.
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_addr,
  input  logic [31:0]           cfg_wdata
);

  // Configuration registers.
  logic [15:0] magic_r;
  logic [7:0]  version_r;
  logic [7:0]  type_lo_r;
  logic [7:0]  type_hi_r;
  logic [31:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= RST_MAGIC;
      version_r <= RST_VERSION;
      type_lo_r <= RST_TYPE_LO;
      type_hi_r <= RST_TYPE_HI;
      limit_r   <= RST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAGIC:   magic_r   <= cfg_wdata[15:0];
        REG_VERSION: version_r <= cfg_wdata[7:0];
        REG_TYPE_LO: type_lo_r <= cfg_wdata[7:0];
        REG_TYPE_HI: type_hi_r <= cfg_wdata[7:0];
        REG_LIMIT:   limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser state.
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [HIDX_W-1:0] hidx_r, hidx_nxt;
  logic              in_pay_r, in_pay_nxt;
  logic [31:0]       left_r, left_nxt;
  logic              failed_r, failed_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  out_data_t         out_data_r, out_data_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_acc;
  logic              out_acc;
  logic [HDR_W-1:0]  hdr_full;
  logic              hdr_done;
  logic              hdr_bad;
  logic              pay_last;
  logic [31:0]       hdr_len;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;

  // The header shifts in from the top, so byte 0 ends up in the low bits.
  assign hdr_full = {in_tdata, hdr_r[HDR_W-1:8]};
  assign hdr_done = (hidx_r == HIDX_W'(HDR_BYTES - 1));
  assign hdr_len  = hdr_full[95:64];
  assign hdr_bad  = (hdr_full[15:0] != magic_r) || (hdr_full[23:16] != version_r) ||
                    (hdr_full[31:24] < type_lo_r) || (hdr_full[31:24] > type_hi_r) ||
                    (hdr_len > limit_r);
  assign pay_last = (left_r <= 32'd1);

  // Per-byte parse step and result formation.
  always_comb begin
    hdr_nxt       = hdr_r;
    hidx_nxt      = hidx_r;
    in_pay_nxt    = in_pay_r;
    left_nxt      = left_r;
    failed_nxt    = failed_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;

    if (in_acc && !failed_r) begin
      if (in_pay_r) begin
        // Payload byte passes straight through.
        out_valid_nxt             = 1'b1;
        out_kind_nxt              = KIND_PAYLOAD;
        out_last_nxt              = pay_last;
        out_data_nxt.frame_type     = hdr_r[31:24];
        out_data_nxt.stream_id      = hdr_r[63:32];
        out_data_nxt.payload_length = hdr_r[95:64];
        out_data_nxt.payload_byte   = in_tdata;
        left_nxt                  = pay_last ? 32'd0 : left_r - 32'd1;
        if (pay_last) begin
          in_pay_nxt = 1'b0;
          hidx_nxt   = '0;
        end
      end else begin
        // Header byte: collect, and check once the last one arrives.
        hdr_nxt = hdr_full;
        if (hdr_done) begin
          hidx_nxt                    = '0;
          out_valid_nxt               = 1'b1;
          out_data_nxt.frame_type     = hdr_full[31:24];
          out_data_nxt.stream_id      = hdr_full[63:32];
          out_data_nxt.payload_length = hdr_len;
          out_data_nxt.payload_byte   = 8'd0;
          if (hdr_bad) begin
            failed_nxt   = 1'b1;
            out_kind_nxt = KIND_ERROR;
            out_last_nxt = 1'b0;
          end else begin
            out_kind_nxt = KIND_HEADER;
            out_last_nxt = (hdr_len == 32'd0);
            if (hdr_len != 32'd0) begin
              in_pay_nxt = 1'b1;
              left_nxt   = hdr_len;
            end
          end
        end else begin
          hidx_nxt = hidx_r + HIDX_W'(1);
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidx_r      <= '0;
      in_pay_r    <= 1'b0;
      left_r      <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hidx_r      <= hidx_nxt;
      in_pay_r    <= in_pay_nxt;
      left_r      <= left_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/tfd_checker.sv
module tfd_checker
  import tfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Once an error word is taken, the output valid drops.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_ERROR |=> !out_tvalid)
    else $error("result after header error");

  // An error word never closes a frame.
  a_err_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERROR |-> !out_tlast)
    else $error("error word flagged as last");

  // Header and error words carry a zero payload byte.
  a_hdr_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PAYLOAD |-> out_tdata[79:72] == 8'd0)
    else $error("nonzero payload byte on header word");

  // Only defined result kinds appear.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == KIND_HEADER || out_tuser == KIND_PAYLOAD ||
                   out_tuser == KIND_ERROR)
    else $error("undefined result kind");

endmodule

bind tunnel_frame_deframer_top tfd_checker u_tfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
